FILE: hdl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types, constants and helpers of the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS    = 31;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = ADDR_W + 1;
	localparam int MOD_W       = SIZE_W + 4;
	localparam int NIB_CNT     = (KEY_BITS + 3) / 4;
	localparam int NIB_W       = NIB_CNT * 4;
	localparam int NIB_CNT_W   = $clog2(NIB_CNT + 1);
	localparam int PROD_W      = KEY_BITS + 32;
	localparam int RECIP_SHIFT = 35;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam int ENTRY_W     = KEY_BITS + 2;
	localparam int CFG_W       = SIZE_W;
	localparam int CFG_IDX_W   = 2;

	localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
	localparam logic [3:0]  DIGIT_BASE = 4'd10;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 2'd1;

	localparam logic [1:0] MODE_LINEAR = 2'd0;
	localparam logic [1:0] MODE_QUAD   = 2'd1;

	localparam logic [1:0] MARK_EMPTY    = 2'd0;
	localparam logic [1:0] MARK_OCCUPIED = 2'd1;
	localparam logic [1:0] MARK_DELETED  = 2'd2;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	typedef struct packed {
		logic [1:0]          op;
		logic [KEY_BITS-1:0] key;
		logic [ADDR_W-1:0]   home;
		logic [ADDR_W-1:0]   rev;
	} work_t;

	typedef struct packed {
		logic [SIZE_W-1:0] n;
		logic [1:0]        mode;
	} cfg_t;

	// v < 16*n, returns v mod n
	function automatic logic [ADDR_W-1:0] mod_small(input logic [MOD_W-1:0] v,
			input logic [SIZE_W-1:0] n);
		logic [MOD_W-1:0] r;
		r = v;
		for (int s = 3; s >= 0; s--) begin
			if (r >= (MOD_W'(n) << s))
				r = r - (MOD_W'(n) << s);
		end
		return r[ADDR_W-1:0];
	endfunction

endpackage

FILE: hdl/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/oaht_front.sv
// ----------------------------------------------------------------------------
// oaht_front
// Accepts a word, computes home slot and digit reversal mod table size.
// ----------------------------------------------------------------------------
module oaht_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [oaht_pkg::KEY_BITS-1:0] key,
	input  logic                          hold,
	input  logic [oaht_pkg::SIZE_W-1:0]   n,
	output logic                          work_valid,
	input  logic                          work_stall,
	output oaht_pkg::work_t               work
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CALC = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t                          st_q;
	logic [1:0]                       op_q;
	logic [oaht_pkg::KEY_BITS-1:0]    key_q;
	logic [oaht_pkg::KEY_BITS-1:0]    k_q;
	logic [oaht_pkg::NIB_W-1:0]       kh_q;
	logic [oaht_pkg::NIB_CNT_W-1:0]   nib_q;
	logic [oaht_pkg::ADDR_W-1:0]      home_q;
	logic [oaht_pkg::ADDR_W-1:0]      rev_q;
	logic [oaht_pkg::QUOT_W-1:0]      quot_q;
	logic                             ph_q;
	logic [oaht_pkg::PROD_W-1:0]      prod;
	logic [3:0]                       digit;
	logic                             accept;

	assign in_stall   = (st_q != F_IDLE) || hold;
	assign accept     = in_valid && !in_stall;
	assign work_valid = (st_q == F_PUSH);
	assign work       = '{op: op_q, key: key_q, home: home_q, rev: rev_q};

	assign prod  = oaht_pkg::PROD_W'(k_q) * oaht_pkg::PROD_W'(oaht_pkg::RECIP_TEN);
	assign digit = 4'(k_q[3:0] - 4'(quot_q[3:0] * oaht_pkg::DIGIT_BASE));

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && accept) begin
			op_q  <= opcode;
			key_q <= key;
			k_q   <= key;
			kh_q  <= oaht_pkg::NIB_W'(key);
		end else if (st_q == F_CALC) begin
			if (nib_q != '0)
				kh_q <= kh_q << 4;
			if (k_q != '0) begin
				if (!ph_q)
					quot_q <= prod[oaht_pkg::RECIP_SHIFT +: oaht_pkg::QUOT_W];
				else
					k_q <= oaht_pkg::KEY_BITS'(quot_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			nib_q  <= '0;
			ph_q   <= 1'b0;
			home_q <= '0;
			rev_q  <= '0;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (accept) begin
						nib_q  <= oaht_pkg::NIB_CNT_W'(oaht_pkg::NIB_CNT);
						ph_q   <= 1'b0;
						home_q <= '0;
						rev_q  <= '0;
						st_q   <= F_CALC;
					end
				end
				F_CALC: begin
					if (nib_q != '0) begin
						home_q <= oaht_pkg::mod_small(
							{home_q, 4'b0000} | oaht_pkg::MOD_W'(kh_q[oaht_pkg::NIB_W-1 -: 4]),
							n);
						nib_q <= nib_q - 1'b1;
					end
					if (k_q != '0) begin
						ph_q <= !ph_q;
						if (ph_q)
							rev_q <= oaht_pkg::mod_small(
								oaht_pkg::MOD_W'(rev_q) * oaht_pkg::MOD_W'(oaht_pkg::DIGIT_BASE)
								+ oaht_pkg::MOD_W'(digit), n);
					end
					if (nib_q == '0 && k_q == '0)
						st_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!work_stall)
						st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/oaht_queue.sv
// ----------------------------------------------------------------------------
// oaht_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module oaht_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  oaht_pkg::work_t in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output oaht_pkg::work_t out_data
);

	oaht_pkg::work_t mem_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rp_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: hdl/oaht_back.sv
// ----------------------------------------------------------------------------
// oaht_back
// Probe engine: clears the slot memory after reset, then walks the probe sequence through it.
// ----------------------------------------------------------------------------
module oaht_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  oaht_pkg::cfg_t              cfg,
	input  logic                        work_valid,
	output logic                        work_stall,
	input  oaht_pkg::work_t             work,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [oaht_pkg::ADDR_W-1:0] slot,
	output logic [oaht_pkg::SIZE_W-1:0] probes
);

	typedef enum logic [3:0] {
		B_CLR   = 4'b0001,
		B_IDLE  = 4'b0010,
		B_PROBE = 4'b0100,
		B_FIN   = 4'b1000
	} bstate_t;

	bstate_t                       st_q;
	oaht_pkg::work_t               w_q;
	logic [oaht_pkg::SIZE_W-1:0]   i_q;
	logic [oaht_pkg::ADDR_W-1:0]   off_q;
	logic [oaht_pkg::ADDR_W-1:0]   inc_q;
	logic [oaht_pkg::SIZE_W-1:0]   clr_q;
	logic                          valid_s1;
	logic [oaht_pkg::ADDR_W-1:0]   slot_s1;
	logic [oaht_pkg::SIZE_W-1:0]   num_s1;
	logic                          res_ok_q;
	logic [oaht_pkg::ADDR_W-1:0]   res_slot_q;
	logic [oaht_pkg::SIZE_W-1:0]   res_probes_q;
	logic                          out_valid_q;
	logic                          ok_q;
	logic [oaht_pkg::ADDR_W-1:0]   slot_q;
	logic [oaht_pkg::SIZE_W-1:0]   probes_q;

	logic [oaht_pkg::SIZE_W-1:0]   n;
	logic [oaht_pkg::SIZE_W-1:0]   sum;
	logic [oaht_pkg::ADDR_W-1:0]   addr;
	logic [oaht_pkg::SIZE_W-1:0]   t_off;
	logic [oaht_pkg::ADDR_W-1:0]   off_nx;
	logic [oaht_pkg::SIZE_W-1:0]   t_inc;
	logic [oaht_pkg::SIZE_W-1:0]   t_inc2;
	logic [oaht_pkg::ADDR_W-1:0]   inc_nx;
	logic [oaht_pkg::ENTRY_W-1:0]  rdata;
	logic [oaht_pkg::ENTRY_W-1:0]  wdata;
	logic [oaht_pkg::ADDR_W-1:0]   waddr;
	logic                          we;
	logic [1:0]                    rmark;
	logic                          hit;
	logic                          out_free;

	assign n        = cfg.n;
	assign clearing = (st_q == B_CLR);
	assign work_stall = (st_q != B_IDLE);
	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign slot      = slot_q;
	assign probes    = probes_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		sum  = oaht_pkg::SIZE_W'(w_q.home) + oaht_pkg::SIZE_W'(off_q);
		addr = (sum >= n) ? oaht_pkg::ADDR_W'(sum - n) : oaht_pkg::ADDR_W'(sum);
		case (cfg.mode)
			oaht_pkg::MODE_LINEAR: t_off = oaht_pkg::SIZE_W'(off_q) + 1'b1;
			oaht_pkg::MODE_QUAD:   t_off = oaht_pkg::SIZE_W'(off_q) + oaht_pkg::SIZE_W'(inc_q);
			default:               t_off = oaht_pkg::SIZE_W'(off_q) + oaht_pkg::SIZE_W'(w_q.rev);
		endcase
		off_nx = (t_off >= n) ? oaht_pkg::ADDR_W'(t_off - n) : oaht_pkg::ADDR_W'(t_off);
		t_inc  = oaht_pkg::SIZE_W'(inc_q) + 2'd2;
		t_inc2 = (t_inc >= n) ? t_inc - n : t_inc;
		inc_nx = (t_inc2 >= n) ? oaht_pkg::ADDR_W'(t_inc2 - n) : oaht_pkg::ADDR_W'(t_inc2);
	end

	assign rmark = rdata[oaht_pkg::KEY_BITS +: 2];
	assign hit   = (w_q.op == oaht_pkg::OP_INSERT) ? (rmark != oaht_pkg::MARK_OCCUPIED) :
		((rmark == oaht_pkg::MARK_OCCUPIED) && (rdata[oaht_pkg::KEY_BITS-1:0] == w_q.key));

	always_comb begin
		we    = 1'b0;
		waddr = slot_s1;
		wdata = '0;
		if (st_q == B_CLR) begin
			we    = 1'b1;
			waddr = clr_q[oaht_pkg::ADDR_W-1:0];
		end else if (st_q == B_PROBE && valid_s1 && hit && w_q.op != oaht_pkg::OP_SEARCH) begin
			we = 1'b1;
			if (w_q.op == oaht_pkg::OP_INSERT)
				wdata = {oaht_pkg::MARK_OCCUPIED, w_q.key};
			else
				wdata = {oaht_pkg::MARK_DELETED, oaht_pkg::KEY_BITS'(0)};
		end
	end

	oaht_ram #(
		.WIDTH(oaht_pkg::ENTRY_W),
		.DEPTH(oaht_pkg::TABLE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && work_valid)
			w_q <= work;
		if (st_q == B_PROBE)
			slot_s1 <= addr;
		if (st_q == B_FIN && out_free) begin
			ok_q     <= res_ok_q;
			slot_q   <= res_slot_q;
			probes_q <= res_probes_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= B_CLR;
			clr_q        <= '0;
			i_q          <= '0;
			off_q        <= '0;
			inc_q        <= '0;
			valid_s1     <= 1'b0;
			num_s1       <= '0;
			res_ok_q     <= 1'b0;
			res_slot_q   <= '0;
			res_probes_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (st_q == B_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (st_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH - 1))
						st_q <= B_IDLE;
				end
				B_IDLE: begin
					if (work_valid) begin
						i_q      <= '0;
						off_q    <= '0;
						inc_q    <= (n == oaht_pkg::SIZE_W'(1)) ? '0 : oaht_pkg::ADDR_W'(1);
						valid_s1 <= 1'b0;
						if (work.op == oaht_pkg::OP_NONE) begin
							res_ok_q     <= 1'b0;
							res_slot_q   <= '0;
							res_probes_q <= '0;
							st_q         <= B_FIN;
						end else begin
							st_q <= B_PROBE;
						end
					end
				end
				B_PROBE: begin
					if (valid_s1 && (hit || num_s1 == n)) begin
						// a miss ends on the last probe, so num_s1 equals n there
						res_ok_q     <= hit;
						res_slot_q   <= hit ? slot_s1 : '0;
						res_probes_q <= num_s1;
						valid_s1     <= 1'b0;
						st_q         <= B_FIN;
					end else if (i_q < n) begin
						valid_s1 <= 1'b1;
						num_s1   <= i_q + 1'b1;
						i_q      <= i_q + 1'b1;
						off_q    <= off_nx;
						inc_q    <= inc_nx;
					end else begin
						valid_s1 <= 1'b0;
					end
				end
				B_FIN: begin
					if (out_free)
						st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_PROBE && valid_s1) |-> (oaht_pkg::SIZE_W'(slot_s1) < n))
		else $error("probe slot outside table");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_PROBE) |-> (i_q <= n))
		else $error("probe count past table size");

	a_ok_probed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ok_q) |-> (probes_q != '0))
		else $error("success without a probe");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_CLR) |-> (!out_valid_q && !we || waddr == clr_q[oaht_pkg::ADDR_W-1:0]))
		else $error("activity during clearing pass");

endmodule

FILE: hdl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressing hash table with linear, quadratic and digit-reversal probing.
// ----------------------------------------------------------------------------
// After reset the block clears the slot marks and holds in_stall high
// meanwhile. The front end takes a word, then works through the key nibbles
// for the home slot and the decimal digits of the key for the reversal, and
// hands the word on before it can accept again. The back end reads one slot
// of the memory per cycle while probing; a miss takes table_size probes. The
// two ends overlap through a two-word queue. A finished result waits in the
// output register; the back end stalls only when its next result is ready
// before that register has been taken.
module open_addressing_hash_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [oaht_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [oaht_pkg::CFG_W-1:0]      wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      opcode,
	input  logic [oaht_pkg::KEY_BITS-1:0]   key,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            ok,
	output logic [oaht_pkg::ADDR_W-1:0]     slot,
	output logic [oaht_pkg::SIZE_W-1:0]     probes
);

	logic [oaht_pkg::SIZE_W-1:0] size_q;
	logic [1:0]                  mode_q;
	oaht_pkg::cfg_t              cfg;
	oaht_pkg::work_t             fw_data;
	oaht_pkg::work_t             qb_data;
	logic                        fw_valid;
	logic                        fw_stall;
	logic                        qb_valid;
	logic                        qb_stall;
	logic                        clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH);
			mode_q <= oaht_pkg::MODE_LINEAR;
		end else if (wr_en) begin
			if (wr_index == oaht_pkg::REG_TABLE_SIZE)
				size_q <= wr_data[oaht_pkg::SIZE_W-1:0];
			else if (wr_index == oaht_pkg::REG_PROBE_MODE)
				mode_q <= wr_data[1:0];
		end
	end

	always_comb begin
		cfg.mode = mode_q;
		if (size_q == '0)
			cfg.n = oaht_pkg::SIZE_W'(1);
		else if (size_q > oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH))
			cfg.n = oaht_pkg::SIZE_W'(oaht_pkg::TABLE_DEPTH);
		else
			cfg.n = size_q;
	end

	oaht_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.key       (key),
		.hold      (clearing),
		.n         (cfg.n),
		.work_valid(fw_valid),
		.work_stall(fw_stall),
		.work      (fw_data)
	);

	oaht_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fw_valid),
		.in_stall (fw_stall),
		.in_data  (fw_data),
		.out_valid(qb_valid),
		.out_stall(qb_stall),
		.out_data (qb_data)
	);

	oaht_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.work_valid(qb_valid),
		.work_stall(qb_stall),
		.work      (qb_data),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ok        (ok),
		.slot      (slot),
		.probes    (probes)
	);

endmodule
